[rtl/plsa_pkg.sv]
package plsa_pkg;

    localparam int MODE_W       = 3;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;
    localparam int LEN_W        = 7;
    localparam int ERR_W        = 2;
    localparam int CAPACITY_DEF = 64;
    localparam int CAPACITY_MAX = 1024;
    localparam int IDX_W        = $clog2(CAPACITY_MAX + 1);
    localparam int GRP_SIZE     = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_ERASE  = 3'd3,
        MODE_READ   = 3'd4,
        MODE_WRITE  = 3'd5
    } t_mode;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2,
        ERR_EMPTY = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic                    rd;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctrl;

endpackage

[rtl/plsa_in_if.sv]
interface plsa_in_if
    import plsa_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

[rtl/plsa_out_if.sv]
interface plsa_out_if
    import plsa_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
    logic [ERR_W-1:0]        error;

    modport source (output valid, output read_value, output length, output error, input ready);
    modport sink   (input valid, input read_value, input length, input error, output ready);
endinterface

[rtl/plsa_cell.sv]
module plsa_cell
    import plsa_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic                    i_clk,
    input  t_cell_ctrl              i_ctrl,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0] o_entry,
    output logic signed [VAL_W-1:0] o_tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;
    logic                    w_hit;
    logic                    w_above;

    assign w_hit   = (i_ctrl.idx == MY_IDX);
    assign w_above = (MY_IDX > i_ctrl.idx);

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
                n_entry = r_entry;
            end
            CELL_LOAD: begin
                if (w_hit) begin
                    n_entry = i_ctrl.value;
                end
            end
            CELL_SHIFT_UP: begin
                if (w_above) begin
                    n_entry = i_left;
                end else if (w_hit) begin
                    n_entry = i_ctrl.value;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (w_above || w_hit) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = (i_ctrl.rd && w_hit) ? r_entry : '0;

endmodule

[rtl/positional_list_shift_array.sv]
// Ordered list of up to CAPACITY signed 32-bit words kept in a row of cells, one word per
// cell. Each transfer on i_in carries one operation (append, remove tail, insert, erase,
// read, write) and produces exactly one transfer on o_out with the word read (zero unless a
// read succeeds), the new length and an error code; failed operations leave the list as it
// was. Every cell compares its own index with the position and shifts or loads in the same
// clock, so one operation is taken per cycle unless o_out stalls, and back-to-back
// operations see each other's effect. The result is held first in an accept register and
// then in the output register, and both hold while o_out stalls; the word for a read is
// collected through a registered OR tree, first over groups of eight cells, then across
// the groups. Entries carry no reset; only entries below the length are ever read. The
// length port is seven bits wide, so capacities above 127 report the length modulo 128.
module positional_list_shift_array
    import plsa_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plsa_in_if.sink    i_in,
    plsa_out_if.source o_out
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CW > POS_W) ? CW : POS_W;
    localparam int GROUPS = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_a_valid;
    logic [LEN_W-1:0]        r_a_len;
    t_err                    r_a_err;
    logic signed [VAL_W-1:0] r_grp [GROUPS];
    logic signed [VAL_W-1:0] w_grp [GROUPS];
    logic                    r_o_valid;
    logic signed [VAL_W-1:0] r_o_rd_value;
    logic [LEN_W-1:0]        r_o_length;
    t_err                    r_o_error;

    logic                    accept;
    logic                    a_move;
    logic [CMP_W-1:0]        pos_x;
    logic [CMP_W-1:0]        cnt_x;
    logic                    full;
    logic                    empty;
    t_err                    err;
    t_cell_op                op;
    logic                    rd;
    logic [IDX_W-1:0]        idx;
    t_cell_ctrl              ctrl;
    logic signed [VAL_W-1:0] gather;

    logic signed [VAL_W-1:0] w_entry [CAPACITY];
    logic signed [VAL_W-1:0] w_tap   [CAPACITY];

    assign a_move     = r_a_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_a_valid || a_move;
    assign accept     = i_in.valid && i_in.ready;

    assign pos_x = CMP_W'(i_in.position);
    assign cnt_x = CMP_W'(r_count);
    assign full  = (r_count == CAP_V);
    assign empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        err     = ERR_OK;
        op      = CELL_HOLD;
        rd      = 1'b0;
        idx     = IDX_W'(i_in.position);
        unique case (i_in.mode)
            MODE_APPEND: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    op      = CELL_LOAD;
                    idx     = IDX_W'(r_count);
                    n_count = r_count + CW'(1);
                end
            end
            MODE_REMOVE: begin
                if (empty) begin
                    err = ERR_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            MODE_INSERT: begin
                if (pos_x > cnt_x) begin
                    err = ERR_RANGE;
                end else if (full) begin
                    err = ERR_FULL;
                end else begin
                    op      = CELL_SHIFT_UP;
                    n_count = r_count + CW'(1);
                end
            end
            MODE_ERASE: begin
                if (empty) begin
                    err = ERR_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    err = ERR_RANGE;
                end else begin
                    op      = CELL_SHIFT_DOWN;
                    n_count = r_count - CW'(1);
                end
            end
            MODE_READ: begin
                if (pos_x >= cnt_x) begin
                    err = ERR_RANGE;
                end else begin
                    rd = 1'b1;
                end
            end
            MODE_WRITE: begin
                if (pos_x >= cnt_x) begin
                    err = ERR_RANGE;
                end else begin
                    op = CELL_LOAD;
                end
            end
            default: begin
                err = ERR_OK;
            end
        endcase
    end

    always_comb begin
        ctrl.op    = accept ? op : CELL_HOLD;
        ctrl.rd    = accept && rd;
        ctrl.idx   = idx;
        ctrl.value = i_in.value;
    end

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;

        if (c == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[c-1];
        end

        if (c == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[c];
        end else begin : g_mid_r
            assign w_right = w_entry[c+1];
        end

        plsa_cell #(
            .INDEX (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[c]),
            .o_tap   (w_tap[c])
        );
    end

    // first level of the read gather
    for (genvar g = 0; g < GROUPS; g++) begin : g_group
        always_comb begin
            w_grp[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                if (g * GRP_SIZE + k < CAPACITY) begin
                    w_grp[g] = w_grp[g] | w_tap[g * GRP_SIZE + k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_grp[g] <= w_grp[g];
            end
        end
    end

    always_comb begin
        gather = '0;
        for (int g = 0; g < GROUPS; g++) begin
            gather = gather | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_len <= LEN_W'(n_count);
            r_a_err <= err;
        end
        if (a_move) begin
            r_o_rd_value <= gather;
            r_o_length   <= r_a_len;
            r_o_error    <= r_a_err;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.read_value = r_o_rd_value;
    assign o_out.length     = r_o_length;
    assign o_out.error      = r_o_error;

endmodule
